>>> rtl/rcq_pkg.sv
// ----------------------------------------------------------------------------
// rcq_pkg
// Shared types, register codes and the per-channel level function of the
// RGB cube palette quantizer.
// ----------------------------------------------------------------------------
package rcq_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_RED_LEVELS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_LEVELS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_LEVELS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ENABLE    = 3'd4;

  localparam logic [8:0] LEVELS_RESET = 9'd6;

  localparam logic FUNC_CONVERT     = 1'b0;
  localparam logic FUNC_TABLE_WRITE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [23:0] dither_noise;
    logic [7:0]  table_address;
    logic [7:0]  table_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] color_index;
    logic       index_overflow;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [8:0] red_levels;
    logic [8:0] green_levels;
    logic [8:0] blue_levels;
    logic       dither_enable;
    logic       map_enable;
  } cfg_regs_t;

  // Scales one channel by its level count and returns the level (sum >> 8).
  function automatic logic [8:0] channel_level(input logic [7:0] c,
                                                input logic [8:0] lv,
                                                input logic [7:0] noise,
                                                input logic       dither);
    logic [17:0] prod;
    logic [17:0] cap;
    logic [17:0] sum;
    prod = 18'(c) * 18'(lv);
    cap  = (18'(lv) << 8) - 18'(lv);
    if (dither) begin
      sum = prod + 18'(noise);
      if (sum > cap) begin
        sum = cap;
      end
    end else begin
      sum = prod + 18'(lv[8:1]);
    end
    return sum[16:8];
  endfunction

endpackage

>>> rtl/rcq_stream_if.sv
// ----------------------------------------------------------------------------
// rcq_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface rcq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/rgb_cube_palette_quantizer_core.sv
// ----------------------------------------------------------------------------
// rgb_cube_palette_quantizer_core
// Result stalls delay a pixel request's result. Throughput: one request per
// cycle while no result stall backs up the pipeline; the translation table
// RAM is read and written in the same pipeline stage, so table writes and
// lookups stay in order.
// Reset: the pipeline empties and the registers return to six levels per
// channel, rounding and direct index; the table is undefined until written.
// ----------------------------------------------------------------------------
module rgb_cube_palette_quantizer_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  rcq_stream_if.sink   in_chan,
  rcq_stream_if.source out_chan,
  rcq_stream_if.sink   cfg_chan
);
  import rcq_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

  cfg_regs_t cfg;

  rcq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic go4, mv3, free3, free2, free1;

  // Stage 1: channel levels.
  logic        func1_r;
  logic [7:0]  addr1_r, val1_r;
  logic [8:0]  lvl_r1_r, lvl_g1_r, lvl_b1_r;
  logic [17:0] rg1_r;
  // Stage 2: weighted cube terms.
  logic        func2_r;
  logic [7:0]  addr2_r, val2_r;
  logic [8:0]  rterm2_r;
  logic [17:0] gterm2_r;
  logic [26:0] bterm2_r;
  // Stage 3: cube index and table access.
  logic        func3_r;
  logic [7:0]  addr3_r, val3_r;
  logic [27:0] cube3_r;
  // Stage 4: result select.
  logic        ovf4_r, use_ram4_r;
  logic [7:0]  direct4_r;

  logic [27:0] cube_nxt;
  logic        in_range3, ovf3, use_ram3, waddr_ok3;
  logic [15:0] waddr_wide;
  logic        ram_we, ram_re;
  logic [7:0]  ram_q;

  assign go4   = !v4_r || out_chan.ready;
  assign mv3   = v3_r && (func3_r || go4);
  assign free3 = !v3_r || mv3;
  assign free2 = !v2_r || free3;
  assign free1 = !v1_r || free2;

  assign in_chan.ready = free1;

  assign v1_nxt = free1 ? in_chan.valid : v1_r;
  assign v2_nxt = free2 ? v1_r : v2_r;
  assign v3_nxt = free3 ? v2_r : v3_r;
  assign v4_nxt = go4 ? (v3_r && !func3_r) : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      func1_r  <= in_chan.payload.func;
      addr1_r  <= in_chan.payload.table_address;
      val1_r   <= in_chan.payload.table_value;
      lvl_r1_r <= channel_level(in_chan.payload.pixel_red, cfg.red_levels,
                                in_chan.payload.dither_noise[7:0], cfg.dither_enable);
      lvl_g1_r <= channel_level(in_chan.payload.pixel_green, cfg.green_levels,
                                in_chan.payload.dither_noise[15:8], cfg.dither_enable);
      lvl_b1_r <= channel_level(in_chan.payload.pixel_blue, cfg.blue_levels,
                                in_chan.payload.dither_noise[23:16], cfg.dither_enable);
      rg1_r    <= 18'(cfg.red_levels) * 18'(cfg.green_levels);
    end
    if (free2) begin
      func2_r  <= func1_r;
      addr2_r  <= addr1_r;
      val2_r   <= val1_r;
      rterm2_r <= lvl_r1_r;
      gterm2_r <= 18'(lvl_g1_r) * 18'(cfg.red_levels);
      bterm2_r <= 27'(lvl_b1_r) * 27'(rg1_r);
    end
    if (free3) begin
      func3_r <= func2_r;
      addr3_r <= addr2_r;
      val3_r  <= val2_r;
      cube3_r <= cube_nxt;
    end
    if (go4) begin
      ovf4_r     <= ovf3;
      use_ram4_r <= use_ram3;
      direct4_r  <= cube3_r[7:0];
    end
  end

  assign cube_nxt = 28'(rterm2_r) + 28'(gterm2_r) + 28'(bterm2_r);

  assign in_range3 = 32'(cube3_r) < DEPTH_W;
  assign ovf3      = cfg.map_enable && !in_range3;
  assign use_ram3  = cfg.map_enable && in_range3;
  assign waddr_ok3 = 32'(addr3_r) < DEPTH_W;
  assign waddr_wide = 16'(addr3_r);

  assign ram_we = v3_r && func3_r && waddr_ok3;
  assign ram_re = mv3 && !func3_r && use_ram3;

  rcq_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_wide[AW-1:0]),
    .wdata (val3_r),
    .re    (ram_re),
    .raddr (cube3_r[AW-1:0]),
    .rdata (ram_q)
  );

  assign out_chan.valid = v4_r;
  always_comb begin
    out_chan.payload.index_overflow = ovf4_r;
    if (use_ram4_r) begin
      out_chan.payload.color_index = ram_q;
    end else if (ovf4_r) begin
      out_chan.payload.color_index = 8'd0;
    end else begin
      out_chan.payload.color_index = direct4_r;
    end
  end

endmodule

>>> rtl/rcq_ram.sv
// ----------------------------------------------------------------------------
// rcq_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
module rcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rcq_cfg.sv
// ----------------------------------------------------------------------------
// rcq_cfg
// Configuration register file: level counts and mode bits, written one
// register per request.
// ----------------------------------------------------------------------------
module rcq_cfg (
  input  logic                clk,
  input  logic                rst_n,
  rcq_stream_if.sink          cfg_chan,
  output rcq_pkg::cfg_regs_t  cfg
);
  import rcq_pkg::*;

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.payload.reg_index)
        REG_RED_LEVELS:    cfg_nxt.red_levels    = cfg_chan.payload.data;
        REG_GREEN_LEVELS:  cfg_nxt.green_levels  = cfg_chan.payload.data;
        REG_BLUE_LEVELS:   cfg_nxt.blue_levels   = cfg_chan.payload.data;
        REG_DITHER_ENABLE: cfg_nxt.dither_enable = cfg_chan.payload.data[0];
        REG_MAP_ENABLE:    cfg_nxt.map_enable    = cfg_chan.payload.data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_levels    <= LEVELS_RESET;
      cfg_r.green_levels  <= LEVELS_RESET;
      cfg_r.blue_levels   <= LEVELS_RESET;
      cfg_r.dither_enable <= 1'b0;
      cfg_r.map_enable    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> bench/rcq_palette_checker.sv
// ----------------------------------------------------------------------------
// rcq_palette_checker
// Watches the pixel, result and register channels of the RGB cube palette
// quantizer. It keeps its own copy of the level registers and the palette
// table, predicts the index of each accepted pixel request and compares each
// result taken, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rcq_palette_checker #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rcq_pkg::in_item_t   in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rcq_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  rcq_pkg::cfg_write_t cfg_item,
  output int                  mismatches,
  output int                  outstanding
);
  import rcq_pkg::*;

  logic [8:0] red_lv;
  logic [8:0] green_lv;
  logic [8:0] blue_lv;
  logic       dither_on;
  logic       map_on;
  logic [7:0] palette_map [TABLE_DEPTH];

  out_item_t  pending_indices [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    red_lv      = LEVELS_RESET;
    green_lv    = LEVELS_RESET;
    blue_lv     = LEVELS_RESET;
    dither_on   = 1'b0;
    map_on      = 1'b0;
  end

  function automatic int channel_step(input logic [7:0] c, input logic [8:0] lv,
                                      input logic [7:0] nz);
    int sum;
    int cap;
    cap = int'(lv) * 255;
    if (dither_on) begin
      sum = int'(c) * int'(lv) + int'(nz);
      if (sum > cap) begin
        sum = cap;
      end
    end else begin
      sum = int'(c) * int'(lv) + int'(lv >> 1);
    end
    return sum >> 8;
  endfunction

  function automatic out_item_t palette_index_of(input in_item_t px);
    longint    r;
    longint    g;
    longint    b;
    longint    cube;
    out_item_t res;
    r = channel_step(px.pixel_red, red_lv, px.dither_noise[7:0]);
    g = channel_step(px.pixel_green, green_lv, px.dither_noise[15:8]);
    b = channel_step(px.pixel_blue, blue_lv, px.dither_noise[23:16]);
    cube = r + g * longint'(red_lv) + b * longint'(red_lv) * longint'(green_lv);
    res.index_overflow = 1'b0;
    if (map_on) begin
      if (cube < TABLE_DEPTH) begin
        res.color_index = palette_map[cube];
      end else begin
        res.color_index    = '0;
        res.index_overflow = 1'b1;
      end
    end else begin
      res.color_index = 8'(cube);
    end
    return res;
  endfunction

  task automatic flag_error(input string msg);
    if (mismatches < 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_item.reg_index)
          REG_RED_LEVELS:    red_lv    = cfg_item.data;
          REG_GREEN_LEVELS:  green_lv  = cfg_item.data;
          REG_BLUE_LEVELS:   blue_lv   = cfg_item.data;
          REG_DITHER_ENABLE: dither_on = cfg_item.data[0];
          REG_MAP_ENABLE:    map_on    = cfg_item.data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_indices.size() == 0) begin
          flag_error($sformatf("unexpected result index %0d overflow %0b",
                               out_item.color_index, out_item.index_overflow));
        end else begin
          want = pending_indices.pop_front();
          if (want.color_index !== out_item.color_index ||
              want.index_overflow !== out_item.index_overflow) begin
            flag_error($sformatf("index expected %0d got %0d, overflow expected %0b got %0b",
                                 want.color_index, out_item.color_index,
                                 want.index_overflow, out_item.index_overflow));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_item.func == FUNC_TABLE_WRITE) begin
          if (in_item.table_address < TABLE_DEPTH) begin
            palette_map[in_item.table_address] = in_item.table_value;
          end
        end else begin
          pending_indices.push_back(palette_index_of(in_item));
        end
      end
    end
    outstanding <= pending_indices.size();
  end

endmodule

>>> bench/rgb_cube_palette_quantizer_core_test.sv
// ----------------------------------------------------------------------------
// rgb_cube_palette_quantizer_core_test
// Drives the RGB cube palette quantizer with directed and random pixel and
// table write requests over a series of level, dither and map settings, with
// random gaps on both sides and one long result stall, and reports the verdict
// of the palette checker.
// ----------------------------------------------------------------------------
module rgb_cube_palette_quantizer_core_test;
  import rcq_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PIPE_FLUSH    = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 80;
  localparam int FIXED_PHASES  = 11;
  localparam int TOTAL_PHASES  = 16;
  localparam int STEADY_PHASE  = 2;
  localparam int HOLD_PHASE    = 7;

  localparam logic [8:0] PH_RED   [FIXED_PHASES] =
    '{9'd16, 9'd16, 9'd256, 9'd256, 9'd1, 9'd0, 9'd511, 9'd511, 9'd257, 9'd6, 9'd0};
  localparam logic [8:0] PH_GREEN [FIXED_PHASES] =
    '{9'd16, 9'd16, 9'd256, 9'd256, 9'd1, 9'd0, 9'd511, 9'd511, 9'd300, 9'd6, 9'd0};
  localparam logic [8:0] PH_BLUE  [FIXED_PHASES] =
    '{9'd2, 9'd2, 9'd256, 9'd256, 9'd1, 9'd0, 9'd511, 9'd511, 9'd0, 9'd6, 9'd0};
  localparam logic PH_DITHER [FIXED_PHASES] =
    '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam logic PH_MAP    [FIXED_PHASES] =
    '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

  logic clk = 1'b0;
  logic rst_n;
  logic steady;
  logic hold_go;
  logic rx_hold;
  int   cycle_count = 0;
  int   mismatches;
  int   outstanding;

  rcq_stream_if #(.payload_t(in_item_t))   in_chan ();
  rcq_stream_if #(.payload_t(out_item_t))  out_chan ();
  rcq_stream_if #(.payload_t(cfg_write_t)) cfg_chan ();

  rgb_cube_palette_quantizer_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  rcq_palette_checker #(.TABLE_DEPTH(256)) palette_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_item     (in_chan.payload),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_item    (out_chan.payload),
    .cfg_valid   (cfg_chan.valid),
    .cfg_ready   (cfg_chan.ready),
    .cfg_item    (cfg_chan.payload),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= !rx_hold && (steady || $urandom_range(99) >= 6);
    end
  end

  // The result side holds off for a long stretch while pixels keep coming.
  initial begin
    rx_hold <= 1'b0;
    @(posedge clk);
    while (!hold_go) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic logic [7:0] pick_component();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [8:0] pick_levels();
    case ($urandom_range(3))
      0:       return 9'($urandom_range(16, 1));
      1:       return 9'($urandom_range(511));
      2:       return 9'($urandom_range(8, 1));
      default: return 9'($urandom_range(300, 200));
    endcase
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    req.func          = ($urandom_range(99) < 10) ? FUNC_TABLE_WRITE : FUNC_CONVERT;
    req.pixel_red     = pick_component();
    req.pixel_green   = pick_component();
    req.pixel_blue    = pick_component();
    case ($urandom_range(5))
      0:       req.dither_noise = 24'h000000;
      1:       req.dither_noise = 24'hFFFFFF;
      default: req.dither_noise = 24'($urandom());
    endcase
    req.table_address = 8'($urandom_range(255));
    req.table_value   = 8'($urandom_range(255));
    return req;
  endfunction

  task automatic send_request(input in_item_t req);
    if (!steady && $urandom_range(99) < 6) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.payload <= req;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [23:0] nz);
    send_request('{func: FUNC_CONVERT, pixel_red: r, pixel_green: g, pixel_blue: b,
                   dither_noise: nz, table_address: 8'hFF, table_value: 8'hFF});
  endtask

  task automatic send_table_write(input logic [7:0] addr, input logic [7:0] val);
    send_request('{func: FUNC_TABLE_WRITE, pixel_red: 8'h00, pixel_green: 8'h00,
                   pixel_blue: 8'h00, dither_noise: 24'h0, table_address: addr,
                   table_value: val});
  endtask

  task automatic drain_pipeline();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
  endtask

  task automatic program_cube(input logic [8:0] rl, input logic [8:0] gl,
                              input logic [8:0] bl, input logic dith,
                              input logic mapen);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{REG_RED_LEVELS, REG_GREEN_LEVELS, REG_BLUE_LEVELS,
            REG_DITHER_ENABLE, REG_MAP_ENABLE};
    val = '{rl, gl, bl, {8'd0, dith}, {8'd0, mapen}};
    for (int k = 0; k < 5; k++) begin
      cfg_chan.valid   <= 1'b1;
      cfg_chan.payload <= '{reg_index: idx[k], data: val[k]};
      do @(posedge clk); while (!cfg_chan.ready);
    end
    cfg_chan.valid <= 1'b0;
  endtask

  initial begin
    rst_n            <= 1'b0;
    steady           <= 1'b0;
    hold_go          <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.payload  <= '0;
    cfg_chan.valid   <= 1'b0;
    cfg_chan.payload <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: six levels per channel, rounding, direct index.
    send_pixel(8'h00, 8'h00, 8'h00, 24'h000000);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
    send_pixel(8'hFF, 8'h00, 8'h00, 24'h000000);
    send_pixel(8'h00, 8'hFF, 8'h00, 24'hFFFFFF);
    send_pixel(8'h00, 8'h00, 8'hFF, 24'h000000);
    send_pixel(8'h80, 8'h40, 8'hC8, 24'hA5A5A5);
    send_table_write(8'h00, 8'hFF);
    send_table_write(8'hFF, 8'h00);
    send_pixel(8'h2A, 8'h2A, 8'h2A, 24'h5A5A5A);

    // Every palette entry is loaded before any lookup can reach it.
    for (int a = 0; a < 256; a++) begin
      send_table_write(8'(a), 8'($urandom_range(255)));
    end

    for (int p = 0; p < TOTAL_PHASES; p++) begin
      drain_pipeline();
      if (p < FIXED_PHASES) begin
        program_cube(PH_RED[p], PH_GREEN[p], PH_BLUE[p], PH_DITHER[p], PH_MAP[p]);
      end else begin
        program_cube(pick_levels(), pick_levels(), pick_levels(),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      steady  <= (p == STEADY_PHASE);
      hold_go <= (p == HOLD_PHASE);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_request(random_request());
      end
    end

    drain_pipeline();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
